/* hdl/csf_pkg.sv */
`default_nettype none

package csf_pkg;

    localparam int PIX_W    = 8;
    localparam int IMG_W_W  = 11;
    localparam int IMG_H_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd768;

    localparam logic MODE_SMOOTH = 1'b0;
    localparam logic MODE_EDGE   = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] down;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] centre;
    } neighbours_t;

    typedef struct packed {
        logic mode;
        logic has_upper;
        logic border;
        logic row_last;
        logic frame_last_row;
    } pos_flags_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             row_end;
        logic             frame_end;
        logic             last_of_run;
    } result_t;

endpackage

`default_nettype wire

/* hdl/csf_ram.sv */
`default_nettype none

module csf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write-first: a read of the address being written returns the new data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
        rd_data_b <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
    end

endmodule

`default_nettype wire

/* hdl/csf_stencil.sv */
`default_nettype none

module csf_stencil (
    input  wire csf_pkg::neighbours_t nb,
    input  wire csf_pkg::pos_flags_t  flags,
    output csf_pkg::result_t          res_first,
    output csf_pkg::result_t          res_second,
    output logic [1:0]                push_cnt
);

    logic [9:0]               ring;
    logic [9:0]               centre_x4;
    logic [10:0]              smooth_sum;
    logic [9:0]               edge_diff;
    logic [csf_pkg::PIX_W-1:0] interior_val;
    logic [csf_pkg::PIX_W-1:0] upper_val;
    csf_pkg::result_t         upper_res;
    csf_pkg::result_t         bottom_res;

    always_comb begin
        ring = 10'(nb.up) + 10'(nb.down) + 10'(nb.left) + 10'(nb.right);
        centre_x4 = {nb.centre, 2'b00};
        smooth_sum = 11'(ring) + 11'(centre_x4);
        edge_diff = ring - centre_x4;
        if (flags.mode == csf_pkg::MODE_EDGE) begin
            interior_val = (ring > centre_x4) ? 8'(edge_diff[9:3]) : '0;
        end else begin
            interior_val = smooth_sum[10:3];
        end

        if (flags.border) begin
            upper_val = (flags.mode == csf_pkg::MODE_EDGE) ? '0 : nb.centre;
        end else begin
            upper_val = interior_val;
        end

        upper_res.pixel_out   = upper_val;
        upper_res.row_end     = flags.row_last;
        upper_res.frame_end   = 1'b0;
        upper_res.last_of_run = !flags.frame_last_row;

        bottom_res.pixel_out   = (flags.mode == csf_pkg::MODE_EDGE) ? '0 : nb.down;
        bottom_res.row_end     = flags.row_last;
        bottom_res.frame_end   = flags.row_last;
        bottom_res.last_of_run = 1'b1;

        res_first  = flags.has_upper ? upper_res : bottom_res;
        res_second = bottom_res;
        push_cnt   = 2'(flags.has_upper) + 2'(flags.frame_last_row);
    end

endmodule

`default_nettype wire

/* hdl/cross_stencil_smooth_edge_filter.sv */
`default_nettype none

// Channel  | Ports                                     | Word contents
// ---------+-------------------------------------------+-------------------------------
// input    | s_tvalid, s_tready, s_tdata[7:0]          | pixel_in
// result   | m_tvalid, m_tready, m_tdata[15:0], m_tlast| pixel_out, row_end, last_of_run;
//          |                                           | m_tlast carries frame_end
// config   | cfg_wr_en, cfg_index, cfg_wdata           | 0 mode, 1 width, 2 height
//
// One input word per cycle while the queue has room, except in the last row of a frame of
// two or more rows; each input word there gives two result words and waits for queue room.
// A result word enters the queue in the cycle after its input word is taken.
// The result path is a four-word queue; s_tready is high while two entries are free.
// Reset empties the queue, clears counters, loads config defaults; line store is not reset.
// The line store uses one registered read per column plus one look-ahead read.

module cross_stencil_smooth_edge_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] pixel_in
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [15:0]                      m_tdata,   // [7:0] pixel_out, [8] row_end,
                                                             // [9] last_of_run, rest zero
    output logic                                  m_tlast,
    input  wire logic                             cfg_wr_en,
    input  wire logic [csf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [csf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > csf_pkg::IMG_W_W) ? COL_W + 1 : csf_pkg::IMG_W_W;
    localparam int LS_W  = 2 * csf_pkg::PIX_W;

    logic                         mode_reg;
    logic [csf_pkg::IMG_W_W-1:0]  width_reg;
    logic [csf_pkg::IMG_H_W-1:0]  height_reg;

    logic [COL_W-1:0]             col_reg, col_next;
    logic [csf_pkg::IMG_H_W-1:0]  row_reg, row_next;
    logic [csf_pkg::PIX_W-1:0]    left_reg, left_next;

    logic [CMP_W-1:0]             eff_width;
    logic [csf_pkg::IMG_H_W-1:0]  eff_height;
    logic                         row_last;
    logic                         frame_last_row;
    logic                         s_accept;
    logic                         m_pop;

    logic [COL_W-1:0]             rd_addr_a;
    logic [COL_W-1:0]             rd_addr_b;
    logic [COL_W:0]               col_next_inc;
    logic [LS_W-1:0]              rd_data_a;
    logic [LS_W-1:0]              rd_data_b;

    csf_pkg::neighbours_t         nb;
    csf_pkg::pos_flags_t          flags;
    csf_pkg::result_t             res_first;
    csf_pkg::result_t             res_second;
    logic [1:0]                   push_cnt;
    logic [1:0]                   push_eff;

    csf_pkg::result_t             fifo_reg [csf_pkg::FIFO_DEPTH];
    logic [csf_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [csf_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [csf_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    csf_pkg::result_t             head;

    always_comb begin
        if (width_reg == '0) begin
            eff_width = CMP_W'(1);
        end else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH)) begin
            eff_width = CMP_W'(MAX_WIDTH);
        end else begin
            eff_width = CMP_W'(width_reg);
        end
        eff_height = (height_reg == '0) ? csf_pkg::IMG_H_W'(1) : height_reg;
        row_last = (CMP_W'(col_reg) + CMP_W'(1)) >= eff_width;
        frame_last_row = (17'(row_reg) + 17'd1) >= 17'(eff_height);
    end

    assign s_tready = count_reg <= csf_pkg::FIFO_CNT_W'(csf_pkg::FIFO_DEPTH - 2);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = count_reg != '0;
    assign m_pop    = m_tvalid && m_tready;

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (s_accept) begin
            if (row_last) begin
                col_next = '0;
                row_next = frame_last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
            if (row_reg != '0) begin
                left_next = rd_data_a[csf_pkg::PIX_W-1:0];
            end
        end
        col_next_inc = {1'b0, col_next} + 1'b1;
        rd_addr_a = col_next;
        rd_addr_b = (col_next_inc == (COL_W+1)'(MAX_WIDTH)) ? '0 : col_next_inc[COL_W-1:0];
    end

    csf_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk      (aclk),
        .wr_en     (s_accept),
        .wr_addr   (col_reg),
        .wr_data   ({rd_data_a[csf_pkg::PIX_W-1:0], s_tdata}),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    always_comb begin
        nb.up     = rd_data_a[LS_W-1:csf_pkg::PIX_W];
        nb.centre = rd_data_a[csf_pkg::PIX_W-1:0];
        nb.right  = rd_data_b[csf_pkg::PIX_W-1:0];
        nb.left   = left_reg;
        nb.down   = s_tdata;
        flags.mode           = mode_reg;
        flags.has_upper      = row_reg != '0;
        flags.border         = (row_reg == csf_pkg::IMG_H_W'(1)) || (col_reg == '0) || row_last;
        flags.row_last       = row_last;
        flags.frame_last_row = frame_last_row;
    end

    csf_stencil u_stencil (
        .nb         (nb),
        .flags      (flags),
        .res_first  (res_first),
        .res_second (res_second),
        .push_cnt   (push_cnt)
    );

    always_comb begin
        push_eff    = s_accept ? push_cnt : 2'd0;
        wr_ptr_next = wr_ptr_reg + csf_pkg::FIFO_PTR_W'(push_eff);
        rd_ptr_next = rd_ptr_reg + csf_pkg::FIFO_PTR_W'(m_pop);
        count_next  = count_reg + csf_pkg::FIFO_CNT_W'(push_eff)
                      - csf_pkg::FIFO_CNT_W'(m_pop);
    end

    always_ff @(posedge aclk) begin
        if (push_eff != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res_first;
        end
        if (push_eff == 2'd2) begin
            fifo_reg[wr_ptr_reg + 1'b1] <= res_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= csf_pkg::MODE_SMOOTH;
            width_reg  <= csf_pkg::IMAGE_WIDTH_RST;
            height_reg <= csf_pkg::IMAGE_HEIGHT_RST;
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    csf_pkg::CFG_FILTER_MODE: begin
                        mode_reg <= cfg_wdata[0];
                    end
                    csf_pkg::CFG_IMAGE_WIDTH: begin
                        width_reg <= cfg_wdata[csf_pkg::IMG_W_W-1:0];
                    end
                    csf_pkg::CFG_IMAGE_HEIGHT: begin
                        height_reg <= cfg_wdata[csf_pkg::IMG_H_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head    = fifo_reg[rd_ptr_reg];
    assign m_tdata = {6'd0, head.last_of_run, head.row_end, head.pixel_out};
    assign m_tlast = head.frame_end;

endmodule

`default_nettype wire
